/* src/tab_stop_expander_top_assert.svh */
// Assertion macros for the tab stop expander.
`ifndef TAB_STOP_EXPANDER_TOP_ASSERT_SVH
`define TAB_STOP_EXPANDER_TOP_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define TSE_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("tse assertion failed");

// Next-cycle implication, sampled on clk, off during reset.
`define TSE_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("tse assertion failed");

`endif

/* src/tse_pkg.sv */
package tse_pkg;

  localparam int CHAR_W = 16;
  localparam int WIDTH_W = 7;
  localparam int COL_W = 6;

  localparam logic [CHAR_W-1:0] TAB_CODE = 16'd9;
  localparam logic [WIDTH_W-1:0] TAB_WIDTH_RST = 7'd8;
  localparam logic [WIDTH_W-1:0] MAX_TAB_WIDTH = 7'd64;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_FILL = 2'b10
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic take;   // input request accepted, load its first result
    logic step;   // load next tab fill result
    logic cfg_wr; // tab width write
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic first_last; // accepted request yields a single result
    logic rem_last;   // next fill result is the last one
  } status_t;

endpackage

/* src/tse_if.sv */
interface tse_in_if;
  import tse_pkg::*;
  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] char_in;
  logic              line_end_in;

  modport source(output valid, char_in, line_end_in, input ready);
  modport sink(input valid, char_in, line_end_in, output ready);
endinterface

interface tse_out_if;
  import tse_pkg::*;
  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] char_out;
  logic              run_last;
  logic              line_end_out;
  logic              line_had_tab;

  modport source(output valid, char_out, run_last, line_end_out, line_had_tab,
                 input ready);
  modport sink(input valid, char_out, run_last, line_end_out, line_had_tab,
               output ready);
endinterface

interface tse_cfg_if;
  import tse_pkg::*;
  logic               valid;
  logic               ready;
  logic [WIDTH_W-1:0] tab_width;

  modport source(output valid, tab_width, input ready);
  modport sink(input valid, tab_width, output ready);
endinterface

/* src/tse_ctrl.sv */
module tse_ctrl
  import tse_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_ready,
  output logic    out_valid,
  input  logic    out_ready,
  input  logic    cfg_valid,
  output logic    cfg_ready,
  input  status_t status,
  output cmd_t    cmd
);

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;

  assign out_free  = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;
  assign cfg_ready = 1'b1;

  always_comb begin
    state_nxt  = state_r;
    in_ready   = 1'b0;
    cmd.take   = 1'b0;
    cmd.step   = 1'b0;
    cmd.cfg_wr = cfg_valid;
    case (state_r)
      ST_IDLE: begin
        in_ready = out_free;
        if (in_valid && out_free) begin
          cmd.take = 1'b1;
          if (!status.first_last) begin
            state_nxt = ST_FILL;
          end
        end
      end
      ST_FILL: begin
        if (out_free) begin
          cmd.step = 1'b1;
          if (status.rem_last) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    if (cmd.take || cmd.step) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

/* src/tse_datapath.sv */
module tse_datapath
  import tse_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  cmd_t               cmd,
  output status_t            status,
  input  logic [CHAR_W-1:0]  char_in,
  input  logic               line_end_in,
  input  logic [WIDTH_W-1:0] cfg_tab_width,
  output logic [CHAR_W-1:0]  char_out,
  output logic               run_last,
  output logic               line_end_out,
  output logic               line_had_tab
);

  logic [WIDTH_W-1:0] width_r;
  logic [COL_W-1:0]   col_r, col_nxt;
  logic               seen_r, seen_nxt;
  logic [WIDTH_W-1:0] rem_r;
  logic               lend_r;
  logic [CHAR_W-1:0]  char_r;
  logic               last_r, lend_out_r, had_r;

  logic [WIDTH_W-1:0] w_eff, col_eff, fill, col_inc;
  logic               in_tab;

  always_comb begin
    if (width_r == '0) begin
      w_eff = WIDTH_W'(1);
    end else if (width_r > MAX_TAB_WIDTH) begin
      w_eff = MAX_TAB_WIDTH;
    end else begin
      w_eff = width_r;
    end
    // position past a lowered width restarts the stop
    col_eff = ({1'b0, col_r} >= w_eff) ? '0 : {1'b0, col_r};
    fill    = w_eff - col_eff;
    col_inc = col_eff + WIDTH_W'(1);
    in_tab  = (char_in == TAB_CODE);
  end

  assign status.first_last = !in_tab || (fill == WIDTH_W'(1));
  assign status.rem_last   = (rem_r == WIDTH_W'(1));

  always_comb begin
    col_nxt  = col_r;
    seen_nxt = seen_r;
    if (cmd.take) begin
      if (line_end_in) begin
        col_nxt  = '0;
        seen_nxt = 1'b0;
      end else if (in_tab) begin
        col_nxt  = '0;
        seen_nxt = 1'b1;
      end else begin
        col_nxt = (col_inc >= w_eff) ? '0 : col_inc[COL_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r <= TAB_WIDTH_RST;
      col_r   <= '0;
      seen_r  <= 1'b0;
    end else begin
      if (cmd.cfg_wr) begin
        width_r <= cfg_tab_width;
      end
      col_r  <= col_nxt;
      seen_r <= seen_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      lend_r     <= line_end_in;
      rem_r      <= fill - WIDTH_W'(1);
      char_r     <= char_in;
      last_r     <= status.first_last;
      lend_out_r <= line_end_in && status.first_last;
      had_r      <= line_end_in && status.first_last && (in_tab || seen_r);
    end else if (cmd.step) begin
      rem_r      <= rem_r - WIDTH_W'(1);
      char_r     <= TAB_CODE;
      last_r     <= status.rem_last;
      lend_out_r <= lend_r && status.rem_last;
      had_r      <= lend_r && status.rem_last;
    end
  end

  assign char_out     = char_r;
  assign run_last     = last_r;
  assign line_end_out = lend_out_r;
  assign line_had_tab = had_r;

endmodule

/* src/tab_stop_expander_top.sv */
// Tab stop expander.
// in_ch  : one request per character (char_in, line_end_in on the last one).
// out_ch : results; an ordinary character gives one result, a tab gives
//          tab fill results (code 9) up to the next multiple of tab_width.
//          run_last marks the last result of a request; line_end_out and
//          line_had_tab come on the final result of the line.
// cfg_ch : writes tab_width (0 acts as 1, above 64 acts as 64); write it
//          only while no request is in flight. Always ready.
// The first result is registered and appears in the cycle after acceptance.
// Output: an ordinary character gives one result; a tab gives tab_width -
//   column fill results (1..64), which the fill counter loads into the single
//   output register each cycle while the sink keeps up; in_ch waits meanwhile.
// While a finished result waits, the next request is still taken if the
//   sink takes the pending one in the same cycle.
// Reset (rst_n low, synchronous): tab_width = 8, column and tab flag
//   cleared, no result pending.
// Sink stall: out_ch holds its result, the fill sequence pauses and
//   in_ch.ready stays low.
module tab_stop_expander_top
  import tse_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  tse_in_if.sink   in_ch,
  tse_out_if.source out_ch,
  tse_cfg_if.sink  cfg_ch
);

  cmd_t    cmd;
  status_t status;

  // control: handshakes, fill sequencing, output valid
  tse_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .cfg_valid (cfg_ch.valid),
    .cfg_ready (cfg_ch.ready),
    .status    (status),
    .cmd       (cmd)
  );

  // datapath: width register, column counter, fill counter, result register
  tse_datapath u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .status        (status),
    .char_in       (in_ch.char_in),
    .line_end_in   (in_ch.line_end_in),
    .cfg_tab_width (cfg_ch.tab_width),
    .char_out      (out_ch.char_out),
    .run_last      (out_ch.run_last),
    .line_end_out  (out_ch.line_end_out),
    .line_had_tab  (out_ch.line_had_tab)
  );

endmodule

/* src/tse_checker.sv */
`include "tab_stop_expander_top_assert.svh"

module tse_checker
  import tse_pkg::*;
(
  input logic              clk,
  input logic              rst_n,
  input logic              out_valid,
  input logic              out_ready,
  input logic [CHAR_W-1:0] char_out,
  input logic              run_last,
  input logic              line_end_out,
  input logic              line_had_tab
);

  // stalled result holds
  `TSE_ASSERT_NEXT(a_out_hold, out_valid && !out_ready,
                   out_valid && $stable(char_out) && $stable(run_last))
  // tab flag only on the line's final result
  `TSE_ASSERT_NOW(a_had_on_end, out_valid && line_had_tab, line_end_out)
  // line end is always the last result of its request
  `TSE_ASSERT_NOW(a_end_is_last, out_valid && line_end_out, run_last)
  // only tab fill results continue a run
  `TSE_ASSERT_NOW(a_fill_is_tab, out_valid && !run_last, char_out == TAB_CODE)

endmodule

bind tab_stop_expander_top tse_checker u_tse_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .char_out     (out_ch.char_out),
  .run_last     (out_ch.run_last),
  .line_end_out (out_ch.line_end_out),
  .line_had_tab (out_ch.line_had_tab)
);

/* tb/tb_top.sv */
// Testbench for tab_stop_expander_top.
// Requests are queued by the sequencing process, sent by a clocked driver and
// predicted when accepted. A clocked monitor checks each result against the
// oldest predicted fill or pass-through result.
module tb_top;
  import tse_pkg::*;

  // Longest quiet stretch of a correct run is the forced sink hold plus one
  // gap. The limit is several times that.
  localparam int STUCK_LIMIT = 1000;
  localparam int LONG_HOLD   = 200;
  localparam int SETTLE      = 4;
  localparam int LINE_MAX    = 12;

  // One character request as queued for the driver.
  typedef struct packed {
    logic [CHAR_W-1:0] ch;
    logic              line_end;
  } char_req_t;

  // One predicted result.
  typedef struct packed {
    logic [CHAR_W-1:0] ch;
    logic              run_last;
    logic              line_end;
    logic              had_tab;
  } tse_result_t;

  logic clk = 1'b0;
  logic rst_n;

  tse_in_if  in_ch();
  tse_out_if out_ch();
  tse_cfg_if cfg_ch();

  tab_stop_expander_top uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Requests waiting for the driver, and results still to come.
  char_req_t   pending_chars[$];
  tse_result_t expected_results[$];

  int unsigned reqs_queued = 0;
  int unsigned reqs_taken  = 0;
  int unsigned mismatch_count = 0;

  // Idle ranges per side, set per phase by the sequencer.
  int unsigned in_idle_max  = 10;
  int unsigned out_idle_max = 10;
  logic        hold_req = 1'b0;

  // Predictor state: its own copy of the register and the line state.
  logic [WIDTH_W-1:0] width_reg = TAB_WIDTH_RST;
  logic [COL_W-1:0]   col_pos   = '0;
  logic               tab_flag  = 1'b0;

  // Expand one accepted request into the results it should produce.
  function automatic void expand_char(input logic [CHAR_W-1:0] ch, input logic line_end);
    int          w;
    int          col;
    int          fill;
    tse_result_t r;
    w = width_reg;
    if (w == 0) w = 1;                  // zero acts as one
    if (w > MAX_TAB_WIDTH) w = MAX_TAB_WIDTH;
    col = col_pos;
    if (col >= w) col = 0;              // width lowered mid-line: restart the stop
    if (ch == TAB_CODE) begin
      tab_flag = 1'b1;
      fill = w - col;
      for (int i = 0; i < fill; i++) begin
        r.ch       = TAB_CODE;
        r.run_last = (i == fill - 1);
        r.line_end = r.run_last & line_end;
        r.had_tab  = r.line_end ? tab_flag : 1'b0;
        expected_results.push_back(r);
      end
      col_pos = '0;
    end else begin
      r.ch       = ch;
      r.run_last = 1'b1;
      r.line_end = line_end;
      r.had_tab  = line_end ? tab_flag : 1'b0;
      expected_results.push_back(r);
      col = col + 1;
      col_pos = (col >= w) ? '0 : COL_W'(col);
    end
    if (line_end) begin
      col_pos  = '0;
      tab_flag = 1'b0;
    end
  endfunction

  // ---------------------------------------------------------------------
  // Driver: sends queued requests, draws an idle gap of up to in_idle_max
  // after each one, and feeds every accepted request to the predictor.
  // Register writes reach the predictor here as well, so one process owns
  // its state.
  // ---------------------------------------------------------------------
  int unsigned src_wait;
  char_req_t   next_req;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      src_wait    <= 0;
      width_reg    = TAB_WIDTH_RST;
      col_pos      = '0;
      tab_flag     = 1'b0;
    end else begin
      if (cfg_ch.valid && cfg_ch.ready) width_reg = cfg_ch.tab_width;
      if (in_ch.valid && in_ch.ready) begin
        expand_char(in_ch.char_in, in_ch.line_end_in);
        reqs_taken++;
      end
      // Slot is free when nothing is offered or the offer was just taken.
      if (!in_ch.valid || in_ch.ready) begin
        if (src_wait != 0) begin
          src_wait    <= src_wait - 1;
          in_ch.valid <= 1'b0;
        end else if (pending_chars.size() != 0) begin
          next_req           = pending_chars.pop_front();
          in_ch.char_in     <= next_req.ch;
          in_ch.line_end_in <= next_req.line_end;
          in_ch.valid       <= 1'b1;
          src_wait          <= $urandom_range(0, in_idle_max);
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // Monitor: checks each result against the oldest expectation, then
  // draws a random stall bounded by out_idle_max. Once per run, on hold_req,
  // it holds ready low for a stretch set by LONG_HOLD so the block backs up.
  // ---------------------------------------------------------------------
  int unsigned sink_wait;
  int unsigned long_hold;
  int unsigned wait_draw;
  logic        long_done;
  tse_result_t want;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      sink_wait    <= 0;
      long_hold    <= 0;
      long_done    <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_results.size() == 0) begin
          $display("%0t: char_out expected none actual %h", $time, out_ch.char_out);
          mismatch_count++;
        end else begin
          want = expected_results.pop_front();
          if (out_ch.char_out !== want.ch) begin
            $display("%0t: char_out expected %h actual %h", $time, want.ch, out_ch.char_out);
            mismatch_count++;
          end
          if (out_ch.run_last !== want.run_last) begin
            $display("%0t: run_last expected %b actual %b", $time, want.run_last,
                     out_ch.run_last);
            mismatch_count++;
          end
          if (out_ch.line_end_out !== want.line_end) begin
            $display("%0t: line_end_out expected %b actual %b", $time, want.line_end,
                     out_ch.line_end_out);
            mismatch_count++;
          end
          if (out_ch.line_had_tab !== want.had_tab) begin
            $display("%0t: line_had_tab expected %b actual %b", $time, want.had_tab,
                     out_ch.line_had_tab);
            mismatch_count++;
          end
        end
      end
      if (hold_req && !long_done) begin
        long_hold    <= LONG_HOLD;
        long_done    <= 1'b1;
        out_ch.ready <= 1'b0;
      end else if (long_hold != 0) begin
        long_hold    <= long_hold - 1;
        out_ch.ready <= (long_hold == 1);
      end else if (out_ch.valid && out_ch.ready) begin
        wait_draw     = $urandom_range(0, out_idle_max);
        sink_wait    <= wait_draw;
        out_ch.ready <= (wait_draw == 0);
      end else if (sink_wait != 0) begin
        sink_wait    <= sink_wait - 1;
        out_ch.ready <= (sink_wait == 1);
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // Watchdog: any handshake clears it; a long quiet stretch ends the run.
  int unsigned stuck_cycles = 0;

  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      stuck_cycles <= 0;
    end else if (stuck_cycles == STUCK_LIMIT) begin
      $display("tab_stop_expander_top: mismatch");
      $finish;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------
  // Sequencer. Runs at the falling edge so queue pushes never meet the
  // driver's pops in the same step.
  // ---------------------------------------------------------------------
  task automatic push_char(input logic [CHAR_W-1:0] ch, input logic line_end);
    char_req_t r;
    r.ch       = ch;
    r.line_end = line_end;
    pending_chars.push_back(r);
    reqs_queued++;
  endtask

  // Every request taken and every result seen, then a settle wait.
  task automatic wait_drained();
    while (reqs_taken != reqs_queued || expected_results.size() != 0) @(negedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // Register write while the block is idle; the line state may be mid-line.
  task automatic write_tab_width(input logic [WIDTH_W-1:0] w);
    wait_drained();
    cfg_ch.tab_width <= w;
    cfg_ch.valid     <= 1'b1;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_ch.valid <= 1'b0;
    @(negedge clk);
  endtask

  // Mostly complete lines with random content; the chunk may cut the
  // last line short so the next width applies mid-line.
  task automatic queue_random_lines(input int count);
    int                n;
    int                len;
    logic [CHAR_W-1:0] ch;
    n = 0;
    while (n < count) begin
      len = $urandom_range(1, LINE_MAX);
      for (int k = 0; k < len && n < count; k++) begin
        ch = ($urandom_range(0, 9) < 3) ? TAB_CODE : CHAR_W'($urandom_range(0, 65535));
        push_char(ch, k == len - 1);
        n++;
      end
    end
  endtask

  logic [WIDTH_W-1:0] chunk_width[8];

  initial begin
    rst_n              = 1'b0;
    in_ch.valid        = 1'b0;
    in_ch.char_in      = '0;
    in_ch.line_end_in  = 1'b0;
    out_ch.ready       = 1'b0;
    cfg_ch.valid       = 1'b0;
    cfg_ch.tab_width   = TAB_WIDTH_RST;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Reset width: mid-stop tabs around code unit extremes, a tab on a stop
    // ending a line, then a line with no tab.
    push_char(16'h0041, 1'b0);
    push_char(TAB_CODE, 1'b0);
    push_char(16'h0000, 1'b0);
    push_char(16'hFFFF, 1'b0);
    push_char(TAB_CODE, 1'b0);
    push_char(TAB_CODE, 1'b1);
    push_char(16'h0042, 1'b1);

    // Width zero acts as one.
    write_tab_width(7'd0);
    push_char(TAB_CODE, 1'b0);
    push_char(16'h0041, 1'b0);
    push_char(TAB_CODE, 1'b1);

    // Width one: each tab is a single fill result.
    write_tab_width(7'd1);
    push_char(16'h007A, 1'b0);
    push_char(TAB_CODE, 1'b1);

    // Above the maximum saturates to 64.
    write_tab_width(7'd127);
    push_char(16'h0061, 1'b0);
    push_char(TAB_CODE, 1'b1);

    // Full width, leave the line open at column 6.
    write_tab_width(MAX_TAB_WIDTH);
    for (int i = 0; i < 6; i++) push_char(CHAR_W'(16'h0061 + i), 1'b0);

    // Lowered below the column: tab gives a full stop of fill.
    write_tab_width(7'd4);
    push_char(TAB_CODE, 1'b0);
    for (int i = 0; i < 3; i++) push_char(16'h0063, 1'b0);

    // Lowered again: an ordinary character restarts the stop.
    write_tab_width(7'd2);
    push_char(16'h0064, 1'b0);
    push_char(TAB_CODE, 1'b1);

    // Random part: one width per chunk, extremes included.
    chunk_width[0] = MAX_TAB_WIDTH;
    chunk_width[1] = 7'd1;
    chunk_width[2] = 7'd0;
    chunk_width[3] = 7'd127;
    chunk_width[4] = 7'd65;
    chunk_width[5] = WIDTH_W'($urandom_range(2, 16));
    chunk_width[6] = WIDTH_W'($urandom_range(0, 127));
    chunk_width[7] = TAB_WIDTH_RST;

    for (int c = 0; c < 8; c++) begin
      write_tab_width(chunk_width[c]);
      if (c == 0) begin
        // Sender keeps offering while the sink holds off: block backs up.
        in_idle_max  = 0;
        out_idle_max = 10;
        hold_req     = 1'b1;
      end else begin
        in_idle_max  = $urandom_range(0, 1) ? 10 : 0;
        out_idle_max = $urandom_range(0, 1) ? 10 : 0;
      end
      queue_random_lines(25);
    end

    wait_drained();
    repeat (8) @(posedge clk);
    if (mismatch_count == 0 && expected_results.size() == 0) begin
      $display("tab_stop_expander_top: match");
    end else begin
      $display("tab_stop_expander_top: mismatch");
    end
    $finish;
  end

endmodule
